@@ rtl/core/grc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and register codes of the grid ray caster.
// Used by grc_div, grc_walk and grid_raycast_column.
package grc_pkg;

    localparam int MAP_SIZE  = 32;
    localparam int MAP_BITS  = $clog2(MAP_SIZE);
    localparam int CW        = MAP_BITS + 2;
    localparam int POS_INT_W = 5;
    localparam int SCREEN_W  = 640;
    localparam int SCREEN_H  = 480;
    localparam int HALF_H    = SCREEN_H / 2;
    localparam int ROW_W     = 9;
    localparam int TEX_SIZE  = 64;
    localparam int TEX_BITS  = $clog2(TEX_SIZE);
    localparam int FRAC      = 16;

    localparam int DQ_W      = 33;
    localparam int DD_W      = 25;
    localparam int DIV_CNT_W = $clog2(DQ_W);
    localparam int SD_W      = 40;
    localparam int RAY_W     = 22;
    localparam int CAM_W     = 20;
    localparam int DIST_W    = 24;
    localparam int LH_W      = 25;
    localparam int TEX_W     = 23;

    localparam int CAM_SH    = 13;
    localparam int CAM_PW    = 31;
    localparam int CAM_MUL   = ((1 << (FRAC + 1 + CAM_SH)) + SCREEN_W - 1) / SCREEN_W;

    localparam logic [DQ_W-1:0]   DX_NUM   = DQ_W'(64'd1 << 32);
    localparam logic [DQ_W-1:0]   LH_NUM   = DQ_W'(SCREEN_H * 65536);
    localparam logic [DQ_W-1:0]   TS_NUM   = DQ_W'(TEX_SIZE * 65536);
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        CFG_POS_X   = 3'd0,
        CFG_POS_Y   = 3'd1,
        CFG_DIR_X   = 3'd2,
        CFG_DIR_Y   = 3'd3,
        CFG_PLANE_X = 3'd4,
        CFG_PLANE_Y = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DQ_W-1:0]      dx;
        logic [DQ_W-1:0]      dy;
        logic [SD_W-1:0]      sdx;
        logic [SD_W-1:0]      sdy;
        logic [POS_INT_W-1:0] mx;
        logic [POS_INT_W-1:0] my;
        logic                 neg_x;
        logic                 neg_y;
        logic                 vx;
        logic                 vy;
    } t_walk_init;

    typedef struct packed {
        logic            esc;
        logic            side;
        logic [SD_W-1:0] sdx;
        logic [SD_W-1:0] sdy;
        logic [3:0]      wall;
    } t_walk_res;

endpackage

@@ rtl/core/grc_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle, shared by the cast sequencer.
// Depends on grc_pkg.
module grc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [grc_pkg::DQ_W-1:0]  i_num,
    input  logic [grc_pkg::DD_W-1:0]  i_den,
    output logic                      o_done,
    output logic [grc_pkg::DQ_W-1:0]  o_quo
);
    import grc_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DD_W-1:0]      r_rem;
    logic [DD_W-1:0]      r_den;
    logic [DQ_W-1:0]      r_q;
    logic [DD_W:0]        trial;
    logic [DD_W:0]        diff;
    logic                 ge;

    assign trial = {r_rem, r_q[DQ_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_den <= i_den;
                r_q   <= i_num;
            end else if (r_run) begin
                r_rem <= ge ? diff[DD_W-1:0] : trial[DD_W-1:0];
                r_q   <= {r_q[DQ_W-2:0], ge};
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DQ_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

@@ rtl/core/grc_walk.sv @@
`timescale 1ns / 1ps
// DDA grid walk over the map memory: one step per cycle, the read data is checked in the next cycle.
// Holds the map RAM and its write port. Depends on grc_pkg.
module grc_walk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  grc_pkg::t_walk_init          i_init,
    input  logic                         i_wr_en,
    input  logic [grc_pkg::MAP_BITS-1:0] i_wr_x,
    input  logic [grc_pkg::MAP_BITS-1:0] i_wr_y,
    input  logic [3:0]                   i_wr_value,
    output logic                         o_done,
    output grc_pkg::t_walk_res           o_res
);
    import grc_pkg::*;

    logic [3:0]              mem [MAP_SIZE*MAP_SIZE];
    logic [3:0]              r_rd_data;
    logic                    r_active;
    logic                    r_pend;
    logic                    r_esc;
    logic                    r_side;
    logic [SD_W-1:0]         r_sdx;
    logic [SD_W-1:0]         r_sdy;
    logic [DQ_W-1:0]         r_dx;
    logic [DQ_W-1:0]         r_dy;
    logic signed [CW-1:0]    r_mx;
    logic signed [CW-1:0]    r_my;
    logic                    r_neg_x;
    logic                    r_neg_y;
    logic                    r_vx;
    logic                    r_vy;

    logic                    step_x;
    logic signed [CW-1:0]    nmx;
    logic signed [CW-1:0]    nmy;
    logic                    in_map;
    logic                    hit;
    logic                    rd_en;
    logic [2*MAP_BITS-1:0]   rd_addr;
    logic signed [CW-1:0]    init_mx;
    logic signed [CW-1:0]    init_my;

    assign step_x = r_vx && (!r_vy || (r_sdx < r_sdy));
    assign nmx = !step_x ? r_mx : (r_neg_x ? r_mx - CW'(1) : r_mx + CW'(1));
    assign nmy = step_x ? r_my : (r_neg_y ? r_my - CW'(1) : r_my + CW'(1));
    assign in_map = !nmx[CW-1] && (nmx < $signed(CW'(MAP_SIZE)))
                 && !nmy[CW-1] && (nmy < $signed(CW'(MAP_SIZE)));
    assign hit     = r_pend && (r_rd_data != 4'd0);
    assign o_done  = r_active && (hit || r_esc);
    assign rd_en   = r_active && !hit && !r_esc && in_map;
    assign rd_addr = {nmx[MAP_BITS-1:0], nmy[MAP_BITS-1:0]};
    assign init_mx = CW'(i_init.mx);
    assign init_my = CW'(i_init.my);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[{i_wr_x, i_wr_y}] <= i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pend   <= 1'b0;
            r_esc    <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_pend   <= 1'b0;
            r_esc    <= (init_mx >= $signed(CW'(MAP_SIZE)))
                     || (init_my >= $signed(CW'(MAP_SIZE)));
            r_side   <= 1'b0;
            r_sdx    <= i_init.sdx;
            r_sdy    <= i_init.sdy;
            r_dx     <= i_init.dx;
            r_dy     <= i_init.dy;
            r_mx     <= init_mx;
            r_my     <= init_my;
            r_neg_x  <= i_init.neg_x;
            r_neg_y  <= i_init.neg_y;
            r_vx     <= i_init.vx;
            r_vy     <= i_init.vy;
        end else if (r_active) begin
            if (hit || r_esc) begin
                r_active <= 1'b0;
                r_pend   <= 1'b0;
            end else begin
                r_mx   <= nmx;
                r_my   <= nmy;
                r_side <= !step_x;
                if (step_x) begin
                    r_sdx <= r_sdx + SD_W'(r_dx);
                end else begin
                    r_sdy <= r_sdy + SD_W'(r_dy);
                end
                r_pend <= in_map;
                r_esc  <= !in_map;
            end
        end
    end

    assign o_res.esc  = r_esc;
    assign o_res.side = r_side;
    assign o_res.sdx  = r_sdx;
    assign o_res.sdy  = r_sdy;
    assign o_res.wall = r_rd_data;

endmodule

@@ rtl/core/grid_raycast_column.sv @@
`timescale 1ns / 1ps
// Grid ray caster top level: config registers, cast sequencer, shared divider, map walk.
// Map write: never busy. Cast: after the start beat the walk runs until it meets a wall or
// leaves the map, then the result strobe is raised; the shared divider runs four passes for a
// wall and two for an escaped ray, each pass skipped when its divisor is zero.
// One item at a time; busy drops with the strobe, which lasts one cycle and cannot stall.
// Reset restores the default view registers and idles the sequencer; map is undefined.
module grid_raycast_column (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [9:0]  i_column,
    input  logic [4:0]  i_cell_x,
    input  logic [4:0]  i_cell_y,
    input  logic [3:0]  i_cell_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    output logic        o_done,
    output logic [9:0]  o_ray_column,
    output logic [3:0]  o_wall_type,
    output logic        o_hit_side,
    output logic        o_escaped,
    output logic [23:0] o_wall_distance,
    output logic [8:0]  o_span_start,
    output logic [8:0]  o_span_end,
    output logic [5:0]  o_texel_column,
    output logic [22:0] o_texel_step,
    output logic [22:0] o_texel_start
);
    import grc_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_CAM   = 12'b000000000010,
        ST_RAY   = 12'b000000000100,
        ST_DX    = 12'b000000001000,
        ST_DY    = 12'b000000010000,
        ST_SD    = 12'b000000100000,
        ST_WALK  = 12'b000001000000,
        ST_DIST  = 12'b000010000000,
        ST_LH    = 12'b000100000000,
        ST_SPAN  = 12'b001000000000,
        ST_TSTEP = 12'b010000000000,
        ST_FIN   = 12'b100000000000
    } t_state;

    t_state r_state;
    logic   r_wait;

    logic [20:0]              r_pos_x;
    logic [20:0]              r_pos_y;
    logic signed [17:0]       r_dir_x;
    logic signed [17:0]       r_dir_y;
    logic signed [17:0]       r_plane_x;
    logic signed [17:0]       r_plane_y;

    logic [9:0]               r_column;
    logic signed [CAM_W-1:0]  r_cam;
    logic signed [RAY_W-1:0]  r_rdx;
    logic signed [RAY_W-1:0]  r_rdy;
    logic [DQ_W-1:0]          r_dx;
    logic [DQ_W-1:0]          r_dy;
    logic [SD_W-1:0]          r_sdx;
    logic [SD_W-1:0]          r_sdy;
    t_walk_res                r_wres;
    logic [DIST_W-1:0]        r_dist;
    logic [LH_W-1:0]          r_lh;
    logic [ROW_W-1:0]         r_ds;
    logic [ROW_W-1:0]         r_de;
    logic [TEX_W-1:0]         r_term;
    logic [TEX_BITS-1:0]      r_tx;
    logic [TEX_W-1:0]         r_tstep;

    logic                     r_done;
    logic [9:0]               r_ray_column;
    logic [3:0]               r_wall_type;
    logic                     r_hit_side;
    logic                     r_escaped;
    logic [DIST_W-1:0]        r_wall_distance;
    logic [ROW_W-1:0]         r_span_start;
    logic [ROW_W-1:0]         r_span_end;
    logic [TEX_BITS-1:0]      r_texel_column;
    logic [TEX_W-1:0]         r_texel_step;
    logic [TEX_W-1:0]         r_texel_start;

    logic                     accept;
    logic                     div_start;
    logic [DQ_W-1:0]          div_num;
    logic [DD_W-1:0]          div_den;
    logic                     div_done;
    logic [DQ_W-1:0]          div_quo;
    logic                     walk_start;
    logic                     walk_done;
    t_walk_init               walk_init;
    t_walk_res                walk_res;

    logic [CAM_PW-1:0]        prod_cam;
    logic [RAY_W-1:0]         abs_x;
    logic [RAY_W-1:0]         abs_y;
    logic signed [37:0]       prod_px;
    logic signed [37:0]       prod_py;
    logic [16:0]              fx;
    logic [16:0]              fy;
    logic [49:0]              prod_sx;
    logic [49:0]              prod_sy;
    logic [SD_W-1:0]          dist_raw;
    logic [LH_W-2:0]          half;
    logic signed [46:0]       prod_w;
    logic [15:0]              wfrac;
    logic [TEX_BITS-1:0]      tx_raw;
    logic                     mirror;
    logic [2*TEX_W-1:0]       prod_ts;

    assign accept      = i_start && !o_busy;
    assign o_busy      = r_state != ST_IDLE;
    assign o_cfg_ready = 1'b1;

    assign prod_cam = CAM_PW'(r_column) * CAM_PW'(CAM_MUL);
    assign abs_x   = r_rdx[RAY_W-1] ? RAY_W'(-r_rdx) : RAY_W'(r_rdx);
    assign abs_y   = r_rdy[RAY_W-1] ? RAY_W'(-r_rdy) : RAY_W'(r_rdy);
    assign prod_px = r_plane_x * r_cam;
    assign prod_py = r_plane_y * r_cam;
    assign fx = r_rdx[RAY_W-1] ? {1'b0, r_pos_x[15:0]} : 17'h10000 - {1'b0, r_pos_x[15:0]};
    assign fy = r_rdy[RAY_W-1] ? {1'b0, r_pos_y[15:0]} : 17'h10000 - {1'b0, r_pos_y[15:0]};
    assign prod_sx = 50'(fx) * 50'(r_dx);
    assign prod_sy = 50'(fy) * 50'(r_dy);

    always_comb begin
        if (!r_wres.side) begin
            dist_raw = r_wres.sdx - SD_W'(r_dx);
        end else if (r_rdy != '0) begin
            dist_raw = r_wres.sdy - SD_W'(r_dy);
        end else begin
            dist_raw = SD_W'(DIST_MAX);
        end
    end

    assign half   = r_lh[LH_W-1:1];
    assign prod_w = $signed({1'b0, r_dist}) * (r_wres.side ? r_rdx : r_rdy);
    assign wfrac  = (r_wres.side ? r_pos_x[15:0] : r_pos_y[15:0]) + prod_w[31:16];
    assign mirror = (!r_wres.side && !r_rdx[RAY_W-1] && (r_rdx != '0))
                 || (r_wres.side && r_rdy[RAY_W-1]);
    assign tx_raw = wfrac[15:16-TEX_BITS];
    assign prod_ts = 46'(r_term) * 46'(r_tstep);

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            ST_DX: begin
                div_start = !r_wait && (r_rdx != '0);
                div_num   = DX_NUM;
                div_den   = DD_W'(abs_x);
            end
            ST_DY: begin
                div_start = !r_wait && (r_rdy != '0);
                div_num   = DX_NUM;
                div_den   = DD_W'(abs_y);
            end
            ST_LH: begin
                div_start = !r_wait && (r_dist != '0);
                div_num   = LH_NUM;
                div_den   = DD_W'(r_dist);
            end
            ST_TSTEP: begin
                div_start = !r_wait && (r_lh != '0);
                div_num   = TS_NUM;
                div_den   = DD_W'(r_lh);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign walk_start      = (r_state == ST_WALK) && !r_wait;
    assign walk_init.dx    = r_dx;
    assign walk_init.dy    = r_dy;
    assign walk_init.sdx   = r_sdx;
    assign walk_init.sdy   = r_sdy;
    assign walk_init.mx    = r_pos_x[20:16];
    assign walk_init.my    = r_pos_y[20:16];
    assign walk_init.neg_x = r_rdx[RAY_W-1];
    assign walk_init.neg_y = r_rdy[RAY_W-1];
    assign walk_init.vx    = r_rdx != '0;
    assign walk_init.vy    = r_rdy != '0;

    grc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    grc_walk u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (walk_start),
        .i_init     (walk_init),
        .i_wr_en    (accept && !i_mode),
        .i_wr_x     (i_cell_x),
        .i_wr_y     (i_cell_y),
        .i_wr_value (i_cell_value),
        .o_done     (walk_done),
        .o_res      (walk_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 21'd1441792;
            r_pos_y   <= 21'd786432;
            r_dir_x   <= -18'sd65536;
            r_dir_y   <= 18'sd0;
            r_plane_x <= 18'sd0;
            r_plane_y <= 18'sd43253;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POS_X:   r_pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_dir_x   <= i_cfg_data[17:0];
                CFG_DIR_Y:   r_dir_y   <= i_cfg_data[17:0];
                CFG_PLANE_X: r_plane_x <= i_cfg_data[17:0];
                CFG_PLANE_Y: r_plane_y <= i_cfg_data[17:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_mode) begin
                        r_column <= i_column;
                        r_wait   <= 1'b0;
                        r_state  <= ST_CAM;
                    end
                end
                ST_CAM: begin
                    r_cam   <= $signed(CAM_W'(prod_cam[CAM_PW-1:CAM_SH]))
                             - $signed(CAM_W'(65536));
                    r_state <= ST_RAY;
                end
                ST_RAY: begin
                    r_rdx   <= RAY_W'(r_dir_x) + RAY_W'(prod_px >>> FRAC);
                    r_rdy   <= RAY_W'(r_dir_y) + RAY_W'(prod_py >>> FRAC);
                    r_state <= ST_DX;
                end
                ST_DX: begin
                    if (!r_wait) begin
                        if (r_rdx == '0) begin
                            r_dx    <= '0;
                            r_state <= ST_DY;
                        end else begin
                            r_wait <= 1'b1;
                        end
                    end else if (div_done) begin
                        r_dx    <= div_quo;
                        r_wait  <= 1'b0;
                        r_state <= ST_DY;
                    end
                end
                ST_DY: begin
                    if (!r_wait) begin
                        if (r_rdy == '0) begin
                            r_dy    <= '0;
                            r_state <= ST_SD;
                        end else begin
                            r_wait <= 1'b1;
                        end
                    end else if (div_done) begin
                        r_dy    <= div_quo;
                        r_wait  <= 1'b0;
                        r_state <= ST_SD;
                    end
                end
                ST_SD: begin
                    r_sdx   <= SD_W'(prod_sx[49:16]);
                    r_sdy   <= SD_W'(prod_sy[49:16]);
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (walk_done) begin
                        r_wres  <= walk_res;
                        r_wait  <= 1'b0;
                        r_state <= walk_res.esc ? ST_FIN : ST_DIST;
                    end
                end
                ST_DIST: begin
                    r_dist  <= (dist_raw > SD_W'(DIST_MAX)) ? DIST_MAX : dist_raw[DIST_W-1:0];
                    r_state <= ST_LH;
                end
                ST_LH: begin
                    if (!r_wait) begin
                        if (r_dist == '0) begin
                            r_lh    <= LH_NUM[LH_W-1:0];
                            r_state <= ST_SPAN;
                        end else begin
                            r_wait <= 1'b1;
                        end
                    end else if (div_done) begin
                        r_lh    <= div_quo[LH_W-1:0];
                        r_wait  <= 1'b0;
                        r_state <= ST_SPAN;
                    end
                end
                ST_SPAN: begin
                    if (half >= (LH_W-1)'(HALF_H)) begin
                        r_ds   <= '0;
                        r_de   <= ROW_W'(SCREEN_H - 1);
                        r_term <= TEX_W'(half - (LH_W-1)'(HALF_H));
                    end else begin
                        r_ds   <= ROW_W'(HALF_H) - half[ROW_W-1:0];
                        r_de   <= half[ROW_W-1:0] + ROW_W'(HALF_H);
                        r_term <= '0;
                    end
                    r_tx    <= mirror ? ~tx_raw : tx_raw;
                    r_state <= ST_TSTEP;
                end
                ST_TSTEP: begin
                    if (!r_wait) begin
                        if (r_lh == '0) begin
                            r_tstep <= TS_NUM[TEX_W-1:0];
                            r_state <= ST_FIN;
                        end else begin
                            r_wait <= 1'b1;
                        end
                    end else if (div_done) begin
                        r_tstep <= div_quo[TEX_W-1:0];
                        r_wait  <= 1'b0;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_ray_column <= r_column;
                    r_hit_side   <= r_wres.side;
                    r_escaped    <= r_wres.esc;
                    if (r_wres.esc) begin
                        r_wall_type     <= '0;
                        r_wall_distance <= DIST_MAX;
                        r_span_start    <= '0;
                        r_span_end      <= '0;
                        r_texel_column  <= '0;
                        r_texel_step    <= '0;
                        r_texel_start   <= '0;
                    end else begin
                        r_wall_type     <= r_wres.wall;
                        r_wall_distance <= r_dist;
                        r_span_start    <= r_ds;
                        r_span_end      <= r_de;
                        r_texel_column  <= r_tx;
                        r_texel_step    <= r_tstep;
                        r_texel_start   <= prod_ts[TEX_W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_ray_column    = r_ray_column;
    assign o_wall_type     = r_wall_type;
    assign o_hit_side      = r_hit_side;
    assign o_escaped       = r_escaped;
    assign o_wall_distance = r_wall_distance;
    assign o_span_start    = r_span_start;
    assign o_span_end      = r_span_end;
    assign o_texel_column  = r_texel_column;
    assign o_texel_step    = r_texel_step;
    assign o_texel_start   = r_texel_start;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result beat while sequencer busy");

    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode) |=> o_busy)
        else $error("cast beat did not start sequencer");

    a_escape_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_escaped) |->
            (o_wall_type == 4'd0) && (o_wall_distance == DIST_MAX) && (o_texel_step == '0))
        else $error("escaped beat carries hit fields");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_escaped) |-> (o_span_start <= o_span_end))
        else $error("span start beyond span end");

endmodule

@@ bench/grid_raycast_column_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for grid_raycast_column: fills the map, casts columns under many views.
// Predicts each cast with a local DDA walk; depends on grc_pkg and the grid_raycast_column RTL.
module grid_raycast_column_tb;
    import grc_pkg::*;

    localparam bit MODE_MAP  = 1'b0;
    localparam bit MODE_CAST = 1'b1;
    localparam int STALL_LIMIT = 20000;
    localparam longint DMAX = 64'd16777215;

    typedef struct {
        bit       mode;
        bit [9:0] column;
        bit [4:0] cx;
        bit [4:0] cy;
        bit [3:0] value;
    } t_cmd;

    typedef struct {
        bit [9:0]  column;
        bit [3:0]  wall;
        bit        side;
        bit        esc;
        bit [23:0] wdist;
        bit [8:0]  ds;
        bit [8:0]  de;
        bit [5:0]  tx;
        bit [22:0] tstep;
        bit [22:0] tstart;
    } t_slice;

    logic        i_clk, i_rst_n, i_start, i_mode, i_cfg_valid;
    logic [9:0]  i_column;
    logic [4:0]  i_cell_x, i_cell_y;
    logic [3:0]  i_cell_value;
    logic [2:0]  i_cfg_index;
    logic [20:0] i_cfg_data;
    logic        o_busy, o_cfg_ready, o_done, o_hit_side, o_escaped;
    logic [9:0]  o_ray_column;
    logic [3:0]  o_wall_type;
    logic [23:0] o_wall_distance;
    logic [8:0]  o_span_start, o_span_end;
    logic [5:0]  o_texel_column;
    logic [22:0] o_texel_step, o_texel_start;

    grid_raycast_column i_dut (.*);

    t_cmd   cmd_q[$];
    t_slice slice_q[$];
    bit [3:0] grid[MAP_SIZE][MAP_SIZE];
    longint view_px, view_py, view_dx, view_dy, view_plx, view_ply;
    bit     cmd_beat, cfg_beat, quiet, failed;
    int     gap, stall;

    function automatic t_slice cast_ray(bit [9:0] column);
        t_slice r;
        longint cam, rdx, rdy, mx, my, sx, sy, dx, dy, sdx, sdy, fx, fy;
        longint wdist, lh, ds, de, wx, tx, tstep;
        bit vx, vy, esc;
        bit side;
        bit [3:0] wall;
        cam = (longint'(column) * 2 * 65536) / SCREEN_W - 65536;
        rdx = view_dx + ((view_plx * cam) >>> 16);
        rdy = view_dy + ((view_ply * cam) >>> 16);
        mx = view_px >> 16;
        my = view_py >> 16;
        vx = rdx != 0;
        vy = rdy != 0;
        dx = vx ? (64'd1 << 32) / (rdx < 0 ? -rdx : rdx) : 0;
        dy = vy ? (64'd1 << 32) / (rdy < 0 ? -rdy : rdy) : 0;
        sx = rdx < 0 ? -1 : 1;
        sy = rdy < 0 ? -1 : 1;
        fx = view_px & 16'hFFFF;
        fy = view_py & 16'hFFFF;
        sdx = ((rdx < 0 ? fx : 65536 - fx) * dx) >> 16;
        sdy = ((rdy < 0 ? fy : 65536 - fy) * dy) >> 16;
        side = 1'b0;
        wall = 4'd0;
        esc = mx >= MAP_SIZE || my >= MAP_SIZE;
        while (!esc) begin
            if (vx && (!vy || sdx < sdy)) begin
                sdx += dx; mx += sx; side = 1'b0;
            end else begin
                sdy += dy; my += sy; side = 1'b1;
            end
            if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) begin
                esc = 1'b1;
            end else begin
                wall = grid[mx][my];
                if (wall != 0) break;
            end
        end
        r = '{default: 0};
        r.column = column;
        r.side = side;
        if (esc) begin
            r.esc = 1'b1;
            r.wdist = 24'(DMAX);
            return r;
        end
        if (side == 0) wdist = vx ? sdx - dx : DMAX;
        else wdist = vy ? sdy - dy : DMAX;
        if (wdist > DMAX) wdist = DMAX;
        lh = wdist == 0 ? SCREEN_H * 65536 : (SCREEN_H * 65536) / wdist;
        ds = HALF_H - lh / 2;
        if (ds < 0) ds = 0;
        de = lh / 2 + HALF_H;
        if (de >= SCREEN_H) de = SCREEN_H - 1;
        tstep = lh == 0 ? TEX_SIZE * 65536 : (TEX_SIZE * 65536) / lh;
        if (side == 0) wx = view_py + ((wdist * rdy) >>> 16);
        else wx = view_px + ((wdist * rdx) >>> 16);
        tx = ((wx & 16'hFFFF) * TEX_SIZE) >> 16;
        if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0)) tx = TEX_SIZE - tx - 1;
        r.wall = wall;
        r.wdist = 24'(wdist);
        r.ds = 9'(ds);
        r.de = 9'(de);
        r.tx = 6'(tx);
        r.tstep = 23'(tstep);
        r.tstart = 23'((ds - HALF_H + lh / 2) * tstep);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // accept beats, update the local view and map, check results
    always @(posedge i_clk) begin
        t_slice e;
        if (i_rst_n && i_start && !o_busy) begin
            cmd_beat = 1'b1;
            if (i_mode == MODE_MAP) grid[i_cell_x][i_cell_y] = i_cell_value;
            else slice_q.push_back(cast_ray(i_column));
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            cfg_beat = 1'b1;
            case (t_cfg_idx'(i_cfg_index))
                CFG_POS_X:   view_px  = longint'(i_cfg_data);
                CFG_POS_Y:   view_py  = longint'(i_cfg_data);
                CFG_DIR_X:   view_dx  = longint'($signed(i_cfg_data[17:0]));
                CFG_DIR_Y:   view_dy  = longint'($signed(i_cfg_data[17:0]));
                CFG_PLANE_X: view_plx = longint'($signed(i_cfg_data[17:0]));
                CFG_PLANE_Y: view_ply = longint'($signed(i_cfg_data[17:0]));
                default: ;
            endcase
        end
        if (i_rst_n && o_done) begin
            if (slice_q.size() == 0) begin
                $display("%0t: result for column %0d with none expected", $time, o_ray_column);
                failed = 1'b1;
            end else begin
                e = slice_q.pop_front();
                if (e.column != o_ray_column || e.wall != o_wall_type
                    || e.side != o_hit_side || e.esc != o_escaped
                    || e.wdist != o_wall_distance || e.ds != o_span_start
                    || e.de != o_span_end || e.tx != o_texel_column
                    || e.tstep != o_texel_step || e.tstart != o_texel_start) begin
                    $display("%0t: mismatch exp col=%0d wall=%0d side=%0d esc=%0d dist=%0d",
                             $time, e.column, e.wall, e.side, e.esc, e.wdist);
                    $display("    exp span=%0d..%0d tx=%0d step=%0d start=%0d",
                             e.ds, e.de, e.tx, e.tstep, e.tstart);
                    $display("    act col=%0d wall=%0d side=%0d esc=%0d dist=%0d",
                             o_ray_column, o_wall_type, o_hit_side, o_escaped,
                             o_wall_distance);
                    $display("    act span=%0d..%0d tx=%0d step=%0d start=%0d",
                             o_span_start, o_span_end, o_texel_column, o_texel_step,
                             o_texel_start);
                    failed = 1'b1;
                end
            end
        end
        if (cmd_beat || cfg_beat || o_done || !i_rst_n) stall = 0;
        else stall++;
        if (stall >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // command driver
    always @(negedge i_clk) begin
        if (cmd_beat) begin
            cmd_beat = 1'b0;
            void'(cmd_q.pop_front());
            if (!quiet && $urandom_range(3) == 0) gap = int'($urandom_range(12, 1));
        end
        if (gap > 0) begin
            gap--;
            i_start <= 1'b0;
        end else if (cmd_q.size() > 0 && i_rst_n) begin
            i_start      <= 1'b1;
            i_mode       <= cmd_q[0].mode;
            i_column     <= cmd_q[0].column;
            i_cell_x     <= cmd_q[0].cx;
            i_cell_y     <= cmd_q[0].cy;
            i_cell_value <= cmd_q[0].value;
        end else begin
            i_start <= 1'b0;
        end
    end

    task automatic add_cell(bit [4:0] x, bit [4:0] y, bit [3:0] v);
        cmd_q.push_back('{MODE_MAP, 10'($urandom), x, y, v});
    endtask

    task automatic add_cast(bit [9:0] c);
        cmd_q.push_back('{MODE_CAST, c, 5'($urandom), 5'($urandom), 4'($urandom)});
    endtask

    task automatic wait_idle();
        while (cmd_q.size() > 0 || i_start || slice_q.size() > 0 || o_busy)
            @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [20:0] data);
        if (!quiet) repeat ($urandom_range(3)) @(negedge i_clk);
        cfg_beat = 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!cfg_beat);
        cfg_beat = 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 21'($urandom);
    endtask

    task automatic set_view(bit [20:0] px, bit [20:0] py, bit [17:0] dx, bit [17:0] dy,
                            bit [17:0] plx, bit [17:0] ply);
        wait_idle();
        write_reg(CFG_DIR_Y, {3'($urandom), dy});
        write_reg(CFG_POS_X, px);
        write_reg(CFG_PLANE_X, {3'($urandom), plx});
        write_reg(CFG_POS_Y, py);
        write_reg(CFG_DIR_X, {3'($urandom), dx});
        write_reg(CFG_PLANE_Y, {3'($urandom), ply});
    endtask

    function automatic bit [3:0] rand_cell(bit border);
        if (border) return $urandom_range(9) == 0 ? 4'd0 : 4'($urandom_range(15, 1));
        return $urandom_range(5) == 0 ? 4'($urandom_range(15, 1)) : 4'd0;
    endfunction

    initial begin
        bit border;
        i_rst_n = 1'b0; i_start = 1'b0; i_mode = 1'b0; i_column = '0;
        i_cell_x = '0; i_cell_y = '0; i_cell_value = '0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        view_px = 1441792; view_py = 786432; view_dx = -65536;
        view_dy = 0; view_plx = 0; view_ply = 43253;
        gap = 0; stall = 0; quiet = 1'b0; failed = 1'b0; cmd_beat = 1'b0; cfg_beat = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full map, walled border with a few openings
        for (int x = 0; x < MAP_SIZE; x++)
            for (int y = 0; y < MAP_SIZE; y++) begin
                border = x == 0 || y == 0 || x == MAP_SIZE - 1 || y == MAP_SIZE - 1;
                add_cell(5'(x), 5'(y), rand_cell(border));
            end
        add_cell(5'd22, 5'd12, 4'd0);
        add_cell(5'd5, 5'd5, 4'd15);
        add_cast(10'd0); add_cast(10'd639); add_cast(10'd320); add_cast(10'd1023);
        add_cast(10'd511);

        // extremes: corners, saturated vectors, zero components, zero ray
        set_view(21'd0, 21'd0, 18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000);
        add_cast(10'd0); add_cast(10'd320); add_cast(10'd1023);
        set_view(21'h1FFFFF, 21'h1FFFFF, 18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF);
        add_cast(10'd0); add_cast(10'd320); add_cast(10'd639);
        set_view(21'h100000, 21'h108000, 18'd0, 18'h10000, 18'h10000, 18'd0);
        add_cast(10'd320); add_cast(10'd100);
        set_view(21'h0F8000, 21'h100000, 18'h10000, 18'd0, 18'd0, 18'h08000);
        add_cast(10'd320); add_cast(10'd600);
        set_view(21'h0B0000, 21'h0C0000, 18'd0, 18'd0, 18'h0C000, 18'h3C000);
        add_cast(10'd320); add_cast(10'd0); add_cast(10'd1023);

        for (int p = 0; p < 26; p++) begin
            if (p >= 21) quiet = 1'b1;
            set_view(21'($urandom), 21'($urandom),
                     $urandom_range(3) == 0 ? 18'd0 : 18'($urandom),
                     $urandom_range(3) == 0 ? 18'd0 : 18'($urandom),
                     $urandom_range(4) == 0 ? 18'd0 : 18'($urandom),
                     $urandom_range(4) == 0 ? 18'd0 : 18'($urandom));
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(7) == 0) begin
                    add_cell(5'($urandom), 5'($urandom), 4'($urandom));
                end
                case ($urandom_range(9))
                    0: add_cast(10'd320);
                    1: add_cast(10'($urandom_range(1023, 640)));
                    default: add_cast(10'($urandom_range(639)));
                endcase
            end
        end

        wait_idle();
        repeat (300) @(negedge i_clk);
        if (!failed && slice_q.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/grc_pkg.sv
rtl/core/grc_div.sv
rtl/core/grc_walk.sv
rtl/core/grid_raycast_column.sv
bench/grid_raycast_column_tb.sv
